// ----- rtl/pli_pkg.sv -----
package pli_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int NORMAL_WIDTH = 16;
   localparam int NORMAL_FRAC  = NORMAL_WIDTH - 2;

   localparam int PROD_W  = COORD_WIDTH + NORMAL_WIDTH;
   localparam int ACC_W   = PROD_W + 2;
   localparam int MAG_W   = ACC_W;
   localparam int LO_W    = MAG_W / 2;
   localparam int HI_W    = MAG_W - LO_W;
   localparam int PP_LO_W = COORD_WIDTH + LO_W;
   localparam int PP_HI_W = COORD_WIDTH + HI_W;
   localparam int PR_W    = COORD_WIDTH + MAG_W;
   localparam int A_W     = PR_W + 2;
   localparam int B_W     = MAG_W + 1;
   localparam int QB      = COORD_WIDTH + 1;
   localparam int R_W     = COORD_WIDTH + 3;
   localparam int SD_W    = MAG_W + 1;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = (COORD_WIDTH > NORMAL_WIDTH) ? COORD_WIDTH : NORMAL_WIDTH;

   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_X     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Y     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Z     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_OFFSET = CSR_IDX_W'(3);

   localparam logic [NORMAL_WIDTH-1:0] NORMAL_ONE = NORMAL_WIDTH'(1) << NORMAL_FRAC;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [B_W-1:0] rem;
      logic [B_W-1:0] div;
      logic [QB-1:0]  dvd;
      logic [QB-1:0]  quo;
      logic           big;
   } pli_lane_type;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] p;
      logic [2:0]                  qsign;
      logic                        hit;
      logic                        front;
      logic [COORD_WIDTH-1:0]      sd;
      logic                        sd_ovf;
   } pli_side_type;

   typedef struct packed {
      pli_lane_type [2:0] lane;
      pli_side_type       side;
   } pli_word_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0]      sd;
      logic                        front;
      logic                        hit;
      logic [2:0][COORD_WIDTH-1:0] hp;
      logic                        ovf;
   } pli_result_type;

endpackage

// ----- rtl/plane_line_intersection_unit.sv -----
// Fully pipelined: one word is accepted per cycle while req_stall is low.
// The depth is set by four arithmetic stages, one cell per quotient bit of the
// rounded divider (33 cells) and the output register.
// A skid register behind the output keeps one extra result while rsp_stall is high.
// Synchronous reset empties the pipeline and loads the plane normal (0, 1, 0), offset 0.
module plane_line_intersection_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [pli_pkg::COORD_WIDTH-1:0]   req_point_x,
   input  logic signed [pli_pkg::COORD_WIDTH-1:0]   req_point_y,
   input  logic signed [pli_pkg::COORD_WIDTH-1:0]   req_point_z,
   input  logic signed [pli_pkg::COORD_WIDTH-1:0]   req_dir_x,
   input  logic signed [pli_pkg::COORD_WIDTH-1:0]   req_dir_y,
   input  logic signed [pli_pkg::COORD_WIDTH-1:0]   req_dir_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [pli_pkg::COORD_WIDTH-1:0]   rsp_signed_distance,
   output logic                                     rsp_front_facing,
   output logic                                     rsp_hit,
   output logic signed [pli_pkg::COORD_WIDTH-1:0]   rsp_hit_x,
   output logic signed [pli_pkg::COORD_WIDTH-1:0]   rsp_hit_y,
   output logic signed [pli_pkg::COORD_WIDTH-1:0]   rsp_hit_z,
   output logic                                     rsp_overflow,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [pli_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [pli_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   localparam int CW = pli_pkg::COORD_WIDTH;
   localparam int NW = pli_pkg::NORMAL_WIDTH;
   localparam int NF = pli_pkg::NORMAL_FRAC;
   localparam int QB = pli_pkg::QB;

   logic [NW-1:0] nx_ff, ny_ff, nz_ff;
   logic [CW-1:0] offset_ff;

   logic pipe_en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   logic signed [NW-1:0] nrm [3];
   logic signed [CW-1:0] pnt [3];
   logic signed [CW-1:0] dir [3];

   logic signed [pli_pkg::PROD_W-1:0] s1_np_ff [3];
   logic signed [pli_pkg::PROD_W-1:0] s1_nd_ff [3];
   logic        [CW-1:0]              s1_p_ff  [3];
   logic        [CW-1:0]              s1_v_ff  [3];

   logic signed [pli_pkg::ACC_W-1:0] s2_num_in, s2_nv_in;
   logic signed [pli_pkg::ACC_W-1:0] s2_num_ff, s2_nv_ff;
   logic        [CW-1:0]             s2_p_ff [3];
   logic        [CW-1:0]             s2_v_ff [3];

   logic                        num_neg, nv_neg;
   logic [pli_pkg::MAG_W-1:0]   num_mag, nv_mag;
   logic [CW-1:0]               vmag [3];
   logic [pli_pkg::SD_W-1:0]    sd_rnd;
   logic [pli_pkg::SD_W-1:0]    sd_lim;
   logic [pli_pkg::PP_LO_W-1:0] s3_pplo_in [3];
   logic [pli_pkg::PP_HI_W-1:0] s3_pphi_in [3];
   pli_pkg::pli_side_type       s3_side_in;
   logic [pli_pkg::PP_LO_W-1:0] s3_pplo_ff [3];
   logic [pli_pkg::PP_HI_W-1:0] s3_pphi_ff [3];
   logic [pli_pkg::MAG_W-1:0]   s3_nvmag_ff;
   pli_pkg::pli_side_type       s3_side_ff;

   logic [pli_pkg::PR_W-1:0]    prod [3];
   logic [pli_pkg::A_W-1:0]     s4_a_in [3];
   logic [pli_pkg::A_W-1:0]     s4_a_ff [3];
   logic [pli_pkg::B_W-1:0]     s4_b_ff;
   pli_pkg::pli_side_type       s4_side_ff;

   pli_pkg::pli_word_type       chain_word [QB+1];
   logic [QB:0]                 chain_valid;

   logic signed [QB:0]          qs  [3];
   logic signed [pli_pkg::R_W-1:0] rsum [3];
   logic [2:0]                  lane_ovf;
   pli_pkg::pli_result_type     res_in;
   pli_pkg::pli_result_type     rsp_word_ff, skid_word_ff;
   logic                        rsp_valid_ff, skid_valid_ff;
   logic                        emerge;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff     <= '0;
         ny_ff     <= pli_pkg::NORMAL_ONE;
         nz_ff     <= '0;
         offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pli_pkg::REG_NORMAL_X:     nx_ff     <= csr_wdata[NW-1:0];
            pli_pkg::REG_NORMAL_Y:     ny_ff     <= csr_wdata[NW-1:0];
            pli_pkg::REG_NORMAL_Z:     nz_ff     <= csr_wdata[NW-1:0];
            pli_pkg::REG_PLANE_OFFSET: offset_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_comb begin
      nrm[0] = $signed(nx_ff);
      nrm[1] = $signed(ny_ff);
      nrm[2] = $signed(nz_ff);
      pnt[0] = req_point_x;
      pnt[1] = req_point_y;
      pnt[2] = req_point_z;
      dir[0] = req_dir_x;
      dir[1] = req_dir_y;
      dir[2] = req_dir_z;
   end

   // Plane sums N.P + D (scaled to the normal's fraction) and N.V.
   always_comb begin
      s2_num_in = pli_pkg::ACC_W'($signed(offset_ff)) <<< NF;
      s2_nv_in  = '0;
      for (int i = 0; i < 3; i++) begin
         s2_num_in = s2_num_in + pli_pkg::ACC_W'(s1_np_ff[i]);
         s2_nv_in  = s2_nv_in + pli_pkg::ACC_W'(s1_nd_ff[i]);
      end
   end

   // Sign and magnitude split, rounded and saturated distance and the split product |V| * |num|.
   always_comb begin
      num_neg = s2_num_ff[pli_pkg::ACC_W-1];
      nv_neg  = s2_nv_ff[pli_pkg::ACC_W-1];
      num_mag = num_neg ? pli_pkg::MAG_W'(-s2_num_ff) : pli_pkg::MAG_W'(s2_num_ff);
      nv_mag  = nv_neg ? pli_pkg::MAG_W'(-s2_nv_ff) : pli_pkg::MAG_W'(s2_nv_ff);
      sd_rnd  = (pli_pkg::SD_W'(num_mag) + (pli_pkg::SD_W'(1) << (NF - 1))) >> NF;
      sd_lim  = (pli_pkg::SD_W'(1) << (CW - 1)) - pli_pkg::SD_W'(!num_neg);
      s3_side_in = '0;
      for (int i = 0; i < 3; i++) begin
         vmag[i] = s2_v_ff[i][CW-1] ? CW'(-s2_v_ff[i]) : s2_v_ff[i];
         s3_pplo_in[i] = pli_pkg::PP_LO_W'(vmag[i])
                         * pli_pkg::PP_LO_W'(num_mag[pli_pkg::LO_W-1:0]);
         s3_pphi_in[i] = pli_pkg::PP_HI_W'(vmag[i])
                         * pli_pkg::PP_HI_W'(num_mag[pli_pkg::MAG_W-1:pli_pkg::LO_W]);
         s3_side_in.p[i]     = s2_p_ff[i];
         s3_side_in.qsign[i] = s2_v_ff[i][CW-1] ^ num_neg ^ nv_neg;
      end
      s3_side_in.hit   = (s2_nv_ff != '0);
      s3_side_in.front = nv_neg || (s2_nv_ff == '0);
      if (sd_rnd > sd_lim) begin
         s3_side_in.sd     = num_neg ? pli_pkg::COORD_MIN : pli_pkg::COORD_MAX;
         s3_side_in.sd_ovf = 1'b1;
      end else begin
         s3_side_in.sd     = num_neg ? CW'(-sd_rnd[CW-1:0]) : sd_rnd[CW-1:0];
         s3_side_in.sd_ovf = 1'b0;
      end
   end

   // Rounded quotient numerator 2|V*num| + |N.V|; the divisor is 2|N.V|.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]    = (pli_pkg::PR_W'(s3_pphi_ff[i]) << pli_pkg::LO_W)
                      + pli_pkg::PR_W'(s3_pplo_ff[i]);
         s4_a_in[i] = (pli_pkg::A_W'(prod[i]) << 1) + pli_pkg::A_W'(s3_nvmag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            s1_np_ff[i] <= pli_pkg::PROD_W'(nrm[i]) * pli_pkg::PROD_W'(pnt[i]);
            s1_nd_ff[i] <= pli_pkg::PROD_W'(nrm[i]) * pli_pkg::PROD_W'(dir[i]);
            s1_p_ff[i]  <= pnt[i];
            s1_v_ff[i]  <= dir[i];
            s2_p_ff[i]  <= s1_p_ff[i];
            s2_v_ff[i]  <= s1_v_ff[i];
            s3_pplo_ff[i] <= s3_pplo_in[i];
            s3_pphi_ff[i] <= s3_pphi_in[i];
            s4_a_ff[i]  <= s4_a_in[i];
         end
         s2_num_ff   <= s2_num_in;
         s2_nv_ff    <= s2_nv_in;
         s3_nvmag_ff <= nv_mag;
         s3_side_ff  <= s3_side_in;
         s4_b_ff     <= {s3_nvmag_ff, 1'b0};
         s4_side_ff  <= s3_side_ff;
      end
   end

   // A quotient of 2^QB or more always saturates the intersection, so it is
   // flagged up front and the cells only develop the low QB bits.
   always_comb begin
      chain_word[0].side = s4_side_ff;
      for (int i = 0; i < 3; i++) begin
         chain_word[0].lane[i].rem = s4_a_ff[i][pli_pkg::A_W-1:QB];
         chain_word[0].lane[i].div = s4_b_ff;
         chain_word[0].lane[i].dvd = s4_a_ff[i][QB-1:0];
         chain_word[0].lane[i].quo = '0;
         chain_word[0].lane[i].big = s4_a_ff[i][pli_pkg::A_W-1:QB] >= s4_b_ff;
      end
   end
   assign chain_valid[0] = s4_valid_ff;

   for (genvar c = 0; c < QB; c++) begin : g_cell
      pli_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (chain_valid[c]),
         .in_word   (chain_word[c]),
         .out_valid (chain_valid[c+1]),
         .out_word  (chain_word[c+1])
      );
   end

   always_comb begin
      res_in.sd    = chain_word[QB].side.sd;
      res_in.front = chain_word[QB].side.front;
      res_in.hit   = chain_word[QB].side.hit;
      for (int i = 0; i < 3; i++) begin
         qs[i]   = chain_word[QB].side.qsign[i] ? -$signed({1'b0, chain_word[QB].lane[i].quo})
                                                 : $signed({1'b0, chain_word[QB].lane[i].quo});
         rsum[i] = pli_pkg::R_W'($signed(chain_word[QB].side.p[i])) - pli_pkg::R_W'(qs[i]);
         if (!chain_word[QB].side.hit) begin
            res_in.hp[i] = '0;
            lane_ovf[i]  = 1'b0;
         end else if (chain_word[QB].lane[i].big) begin
            res_in.hp[i] = chain_word[QB].side.qsign[i] ? pli_pkg::COORD_MAX
                                                        : pli_pkg::COORD_MIN;
            lane_ovf[i]  = 1'b1;
         end else if (rsum[i] > pli_pkg::R_W'(pli_pkg::COORD_MAX)) begin
            res_in.hp[i] = pli_pkg::COORD_MAX;
            lane_ovf[i]  = 1'b1;
         end else if (rsum[i] < pli_pkg::R_W'(pli_pkg::COORD_MIN)) begin
            res_in.hp[i] = pli_pkg::COORD_MIN;
            lane_ovf[i]  = 1'b1;
         end else begin
            res_in.hp[i] = rsum[i][CW-1:0];
            lane_ovf[i]  = 1'b0;
         end
      end
      res_in.ovf = chain_word[QB].side.sd_ovf || (|lane_ovf);
   end

   assign emerge = chain_valid[QB] && pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_word_ff   <= skid_word_ff;
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_word_ff  <= res_in;
            rsp_valid_ff <= emerge;
         end
      end else if (emerge) begin
         skid_word_ff  <= res_in;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_signed_distance = rsp_word_ff.sd;
   assign rsp_front_facing    = rsp_word_ff.front;
   assign rsp_hit             = rsp_word_ff.hit;
   assign rsp_hit_x           = rsp_word_ff.hp[0];
   assign rsp_hit_y           = rsp_word_ff.hp[1];
   assign rsp_hit_z           = rsp_word_ff.hp[2];
   assign rsp_overflow        = rsp_word_ff.ovf;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held while the output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("stalled result word was dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit |-> rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0)
      else $error("intersection point not cleared for a parallel line");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit |-> rsp_front_facing)
      else $error("parallel line not reported as front facing");

endmodule

// ----- rtl/pli_cell.sv -----
module pli_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  pli_pkg::pli_word_type in_word,
   output logic                  out_valid,
   output pli_pkg::pli_word_type out_word
);

   logic                                valid_ff;
   pli_pkg::pli_word_type               word_ff;
   pli_pkg::pli_word_type               word_in;
   logic [2:0][pli_pkg::B_W:0]          trial;
   logic [2:0][pli_pkg::B_W:0]          diff;
   logic [2:0]                          ge;

   // One restoring division step per lane: shift in the next dividend bit,
   // subtract the divisor when it fits and record the quotient bit.
   always_comb begin
      word_in = in_word;
      for (int l = 0; l < 3; l++) begin
         trial[l] = {in_word.lane[l].rem, in_word.lane[l].dvd[pli_pkg::QB-1]};
         diff[l]  = trial[l] - {1'b0, in_word.lane[l].div};
         ge[l]    = trial[l] >= {1'b0, in_word.lane[l].div};
         word_in.lane[l].rem = ge[l] ? diff[l][pli_pkg::B_W-1:0]
                                     : trial[l][pli_pkg::B_W-1:0];
         word_in.lane[l].dvd = {in_word.lane[l].dvd[pli_pkg::QB-2:0], 1'b0};
         word_in.lane[l].quo = {in_word.lane[l].quo[pli_pkg::QB-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
